### rtl/core/mssc_pkg.sv
// Shared types and constants for the TCP SYN MSS clamp core.
`timescale 1ns / 1ps
`default_nettype none
package mssc_pkg;

	localparam int unsigned QUEUE_DEPTH_DEF = 4;

	localparam logic [7:0] OPT_KIND_NOP = 8'd1;
	localparam logic [7:0] OPT_KIND_MSS = 8'd2;
	localparam logic [7:0] OPT_LEN_MSS  = 8'd4;
	localparam logic [15:0] MIN_HDRS    = 16'd40;

	localparam logic [2:0] VERDICT_PASS      = 3'd0;
	localparam logic [2:0] VERDICT_BAD_LEN   = 3'd1;
	localparam logic [2:0] VERDICT_BAD_MTU   = 3'd2;
	localparam logic [2:0] VERDICT_NO_MSS    = 3'd3;
	localparam logic [2:0] VERDICT_MSS_KEPT  = 3'd4;
	localparam logic [2:0] VERDICT_MSS_CLAMP = 3'd5;

	// Everything the back end needs to judge one segment.
	typedef struct packed {
		logic        syn;
		logic        rst;
		logic [3:0]  header_words;
		logic [6:0]  seg_len;
		logic [15:0] path_mtu;
		logic [15:0] reverse_mtu;
		logic        mss_found;
		logic [15:0] mss_value;
		logic [5:0]  mss_offset;
		logic [15:0] checksum;
	} mssc_seg_t;

endpackage
`default_nettype wire

### rtl/core/mssc_front.sv
// Byte-serial TCP header parser that emits one summary per segment.
`timescale 1ns / 1ps
`default_nettype none
module mssc_front
	import mssc_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [7:0]  seg_byte,
	input  wire logic        seg_last,
	input  wire logic [15:0] path_mtu,
	input  wire logic [15:0] reverse_mtu,
	input  wire logic        q_full,
	output logic             q_push,
	output mssc_seg_t        q_data
);

	localparam logic [2:0] PH_KIND = 3'd0;
	localparam logic [2:0] PH_LEN  = 3'd1;
	localparam logic [2:0] PH_HI   = 3'd2;
	localparam logic [2:0] PH_LO   = 3'd3;
	localparam logic [2:0] PH_DONE = 3'd4;

	logic [6:0]  byte_count_q;
	logic [3:0]  header_words_q;
	logic [1:0]  syn_rst_q;
	logic [15:0] checksum_q;
	logic [6:0]  next_opt_q;
	logic [2:0]  phase_q;
	logic [7:0]  kind_q;
	logic        found_q;
	logic [15:0] mss_value_q;
	logic [5:0]  mss_offset_q;

	logic [3:0]  header_words_d;
	logic [1:0]  syn_rst_d;
	logic [15:0] checksum_d;
	logic [6:0]  next_opt_d;
	logic [2:0]  phase_d;
	logic [7:0]  kind_d;
	logic        found_d;
	logic [15:0] mss_value_d;
	logic [5:0]  mss_offset_d;
	logic [6:0]  byte_count_d;

	logic        accept;
	logic        parse_en;
	logic [5:0]  pos;
	logic [5:0]  hdr;
	logic        opt_en;
	logic [5:0]  kpos;
	logic [7:0]  adv;
	logic [8:0]  nxt;
	logic        mss_ok;

	assign in_stall = q_full;
	assign accept   = in_valid && !q_full;
	assign parse_en = !byte_count_q[6];
	assign pos      = byte_count_q[5:0];
	assign hdr      = {header_words_q, 2'b00};
	assign opt_en   = parse_en && (pos >= 6'd20) && (pos < hdr) && !found_q;
	assign kpos     = pos - 6'd1;
	assign adv      = (seg_byte == 8'd0) ? 8'd1 : seg_byte;
	assign nxt      = {3'b000, kpos} + {1'b0, adv};
	assign mss_ok   = (kind_q == OPT_KIND_MSS) && (seg_byte == OPT_LEN_MSS) &&
		(({1'b0, pos} + 7'd3) <= {1'b0, hdr});

	always_comb begin
		header_words_d = header_words_q;
		syn_rst_d      = syn_rst_q;
		checksum_d     = checksum_q;
		next_opt_d     = next_opt_q;
		phase_d        = phase_q;
		kind_d         = kind_q;
		found_d        = found_q;
		mss_value_d    = mss_value_q;
		mss_offset_d   = mss_offset_q;
		byte_count_d   = parse_en ? byte_count_q + 7'd1 : byte_count_q;

		if (parse_en) begin
			if (pos == 6'd12) header_words_d = seg_byte[7:4];
			if (pos == 6'd13) syn_rst_d = {seg_byte[2], seg_byte[1]};
			if (pos == 6'd16) checksum_d[15:8] = seg_byte;
			if (pos == 6'd17) checksum_d[7:0] = seg_byte;
		end

		if (opt_en) begin
			case (phase_q)
				PH_KIND: begin
					if ({1'b0, pos} == next_opt_q) begin
						kind_d = seg_byte;
						if (seg_byte <= OPT_KIND_NOP) begin
							next_opt_d = {1'b0, pos} + 7'd1;
						end else begin
							phase_d = PH_LEN;
						end
					end
				end
				PH_LEN: begin
					if (mss_ok) begin
						phase_d      = PH_HI;
						mss_offset_d = pos + 6'd1;
					end else begin
						phase_d = PH_KIND;
						// A one-byte advance lands on this byte: it is read again as a kind.
						if (nxt == {3'b000, pos}) begin
							kind_d = seg_byte;
							if (seg_byte <= OPT_KIND_NOP) begin
								next_opt_d = {1'b0, pos} + 7'd1;
							end else begin
								phase_d = PH_LEN;
							end
						end else begin
							next_opt_d = (nxt > 9'd127) ? 7'd127 : nxt[6:0];
						end
					end
				end
				PH_HI: begin
					mss_value_d = {seg_byte, 8'h00};
					phase_d     = PH_LO;
				end
				PH_LO: begin
					mss_value_d = {mss_value_q[15:8], seg_byte};
					found_d     = 1'b1;
					phase_d     = PH_DONE;
				end
				default: begin
				end
			endcase
		end
	end

	assign q_push = accept && seg_last;

	always_comb begin
		q_data.syn          = syn_rst_d[0];
		q_data.rst          = syn_rst_d[1];
		q_data.header_words = header_words_d;
		q_data.seg_len      = byte_count_q + 7'd1;
		q_data.path_mtu     = path_mtu;
		q_data.reverse_mtu  = reverse_mtu;
		q_data.mss_found    = found_d;
		q_data.mss_value    = mss_value_d;
		q_data.mss_offset   = mss_offset_d;
		q_data.checksum     = checksum_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_count_q   <= '0;
			header_words_q <= '0;
			syn_rst_q      <= '0;
			checksum_q     <= '0;
			next_opt_q     <= 7'd20;
			phase_q        <= PH_KIND;
			kind_q         <= '0;
			found_q        <= 1'b0;
			mss_value_q    <= '0;
			mss_offset_q   <= '0;
		end else if (accept) begin
			if (seg_last) begin
				byte_count_q   <= '0;
				header_words_q <= '0;
				syn_rst_q      <= '0;
				checksum_q     <= '0;
				next_opt_q     <= 7'd20;
				phase_q        <= PH_KIND;
				kind_q         <= '0;
				found_q        <= 1'b0;
				mss_value_q    <= '0;
				mss_offset_q   <= '0;
			end else begin
				byte_count_q   <= byte_count_d;
				header_words_q <= header_words_d;
				syn_rst_q      <= syn_rst_d;
				checksum_q     <= checksum_d;
				next_opt_q     <= next_opt_d;
				phase_q        <= phase_d;
				kind_q         <= kind_d;
				found_q        <= found_d;
				mss_value_q    <= mss_value_d;
				mss_offset_q   <= mss_offset_d;
			end
		end
	end

endmodule
`default_nettype wire

### rtl/core/mssc_queue.sv
// Short queue of segment summaries between the parser and the verdict stages.
`timescale 1ns / 1ps
`default_nettype none
module mssc_queue
	import mssc_pkg::*;
#(
	parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      push,
	input  wire mssc_seg_t push_data,
	output logic           full,
	input  wire logic      pop,
	output logic           not_empty,
	output mssc_seg_t      pop_data
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	mssc_seg_t        entry_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full      = (count_q == FULL_CNT);
	assign not_empty = (count_q != '0);
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;
	assign pop_data  = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) entry_q[wr_ptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			if (do_pop) rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			if (do_push && !do_pop) count_q <= count_q + 1'b1;
			else if (do_pop && !do_push) count_q <= count_q - 1'b1;
		end
	end

endmodule
`default_nettype wire

### rtl/core/mssc_back.sv
// Verdict, MSS clamp and incremental checksum update, three register stages deep.
`timescale 1ns / 1ps
`default_nettype none
module mssc_back
	import mssc_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      q_not_empty,
	input  wire mssc_seg_t q_data,
	output logic       q_pop,
	output logic       out_valid,
	input  wire logic  out_stall,
	output logic [2:0]  verdict,
	output logic [5:0]  mss_position,
	output logic [15:0] old_mss,
	output logic [15:0] new_mss,
	output logic [15:0] new_checksum
);

	logic        v_s1;
	logic [2:0]  verdict_s1;
	logic [5:0]  pos_s1;
	logic [15:0] old_s1;
	logic [15:0] new_s1;
	logic [15:0] ck_s1;

	logic        v_s2;
	logic [2:0]  verdict_s2;
	logic [5:0]  pos_s2;
	logic [15:0] old_s2;
	logic [15:0] new_s2;
	logic [15:0] ck_s2;
	logic [17:0] sum_s2;

	logic        out_v_q;
	logic [2:0]  verdict_q;
	logic [5:0]  pos_q;
	logic [15:0] old_q;
	logic [15:0] new_q;
	logic [15:0] ck_q;

	logic        load_out;
	logic        load_s2;
	logic        load_s1;

	logic [15:0] min_mtu;
	logic [15:0] target;
	logic [2:0]  verdict_c;
	logic [16:0] fold1;
	logic [15:0] fold2;

	assign load_out = !out_v_q || !out_stall;
	assign load_s2  = !v_s2 || load_out;
	assign load_s1  = !v_s1 || load_s2;
	assign q_pop    = q_not_empty && load_s1;

	assign min_mtu = (q_data.path_mtu < q_data.reverse_mtu) ? q_data.path_mtu
		: q_data.reverse_mtu;
	assign target  = min_mtu - MIN_HDRS;

	always_comb begin
		if (!q_data.syn || q_data.rst) verdict_c = VERDICT_PASS;
		else if (q_data.seg_len != {1'b0, q_data.header_words, 2'b00})
			verdict_c = VERDICT_BAD_LEN;
		else if (q_data.path_mtu <= MIN_HDRS) verdict_c = VERDICT_BAD_MTU;
		else if (!q_data.mss_found) verdict_c = VERDICT_NO_MSS;
		else if (q_data.mss_value <= target) verdict_c = VERDICT_MSS_KEPT;
		else verdict_c = VERDICT_MSS_CLAMP;
	end

	// One's complement fold of the RFC 1624 sum, done after the s2 register.
	assign fold1 = {1'b0, sum_s2[15:0]} + {15'd0, sum_s2[17:16]};
	assign fold2 = fold1[15:0] + {15'd0, fold1[16]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (load_s1) v_s1 <= q_not_empty;
			if (load_s2) v_s2 <= v_s1;
			if (load_out) out_v_q <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1 && q_not_empty) begin
			verdict_s1 <= verdict_c;
			ck_s1      <= q_data.checksum;
			if (verdict_c == VERDICT_MSS_KEPT || verdict_c == VERDICT_MSS_CLAMP) begin
				pos_s1 <= q_data.mss_offset;
				old_s1 <= q_data.mss_value;
				new_s1 <= (verdict_c == VERDICT_MSS_CLAMP) ? target : q_data.mss_value;
			end else begin
				pos_s1 <= '0;
				old_s1 <= '0;
				new_s1 <= '0;
			end
		end
		if (load_s2 && v_s1) begin
			verdict_s2 <= verdict_s1;
			pos_s2     <= pos_s1;
			old_s2     <= old_s1;
			new_s2     <= new_s1;
			ck_s2      <= ck_s1;
			sum_s2     <= {2'b00, ~ck_s1} + {2'b00, ~old_s1} + {2'b00, new_s1};
		end
		if (load_out && v_s2) begin
			verdict_q <= verdict_s2;
			pos_q     <= pos_s2;
			old_q     <= old_s2;
			new_q     <= new_s2;
			ck_q      <= (verdict_s2 == VERDICT_MSS_CLAMP) ? ~fold2 : ck_s2;
		end
	end

	assign out_valid    = out_v_q;
	assign verdict      = verdict_q;
	assign mss_position = pos_q;
	assign old_mss      = old_q;
	assign new_mss      = new_q;
	assign new_checksum = ck_q;

endmodule
`default_nettype wire

### rtl/core/tcp_syn_mss_clamp_core.sv
// Top level of the TCP SYN MSS clamp: parser, summary queue and verdict stages.
// Takes one segment byte per cycle while in_stall is low, with no gaps between segments.
// After the last byte of a segment is accepted, its result word passes through the summary queue,
// then the verdict, checksum-sum and output register stages.
// in_stall rises only when the summary queue is full, which needs output back-pressure.
// Reset clears the parser state, the queue pointers and every stage valid bit.
`timescale 1ns / 1ps
`default_nettype none
module tcp_syn_mss_clamp_core
	import mssc_pkg::*;
#(
	parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [7:0]  seg_byte,
	input  wire logic        seg_last,
	input  wire logic [15:0] path_mtu,
	input  wire logic [15:0] reverse_mtu,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [2:0]       verdict,
	output logic [5:0]       mss_position,
	output logic [15:0]      old_mss,
	output logic [15:0]      new_mss,
	output logic [15:0]      new_checksum
);

	logic      q_full;
	logic      q_push;
	logic      q_pop;
	logic      q_not_empty;
	mssc_seg_t q_wdata;
	mssc_seg_t q_rdata;

	mssc_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.seg_byte    (seg_byte),
		.seg_last    (seg_last),
		.path_mtu    (path_mtu),
		.reverse_mtu (reverse_mtu),
		.q_full      (q_full),
		.q_push      (q_push),
		.q_data      (q_wdata)
	);

	mssc_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_wdata),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_not_empty),
		.pop_data  (q_rdata)
	);

	mssc_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_not_empty  (q_not_empty),
		.q_data       (q_rdata),
		.q_pop        (q_pop),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.verdict      (verdict),
		.mss_position (mss_position),
		.old_mss      (old_mss),
		.new_mss      (new_mss),
		.new_checksum (new_checksum)
	);

	// Without a usable MSS option the position and values are reported as zero.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && verdict != VERDICT_MSS_KEPT && verdict != VERDICT_MSS_CLAMP
		|-> mss_position == 6'd0 && old_mss == 16'd0 && new_mss == 16'd0)
		else $error("MSS fields set without an MSS verdict");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && verdict == VERDICT_MSS_KEPT |-> new_mss == old_mss)
		else $error("kept MSS differs from the found one");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && verdict == VERDICT_MSS_CLAMP |-> new_mss < old_mss)
		else $error("clamped MSS is not smaller than the found one");

	// A full queue must hold off the parser so that no summary is dropped.
	assert property (@(posedge clk) disable iff (!arst_n)
		q_full |-> in_stall)
		else $error("parser not stalled while the queue is full");

endmodule
`default_nettype wire
